// ===== rtl/core/convex_hull_point_query_defines.svh =====
// Assertion macros shared by the point query RTL.
// Depends on nothing; included by the top level.
`ifndef CONVEX_HULL_POINT_QUERY_DEFINES_SVH
`define CONVEX_HULL_POINT_QUERY_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset
`define CHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chpq assertion failed");

// Next-cycle implication under synchronous active-low reset
`define CHPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chpq assertion failed");

`endif

// ===== rtl/core/chpq_pkg.sv =====
// Types and codes of the convex hull point query block.
// No dependencies; used by the interfaces and the top level.
package chpq_pkg;

    // Input function codes
    localparam logic [1:0] FN_VERTEX = 2'd0;
    localparam logic [1:0] FN_FACET  = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FACET_COUNT   = 1'b0;
    localparam logic CFG_INSIDE_MARGIN = 1'b1;

    // Datapath widths
    localparam int MUL_W  = 36;
    localparam int PROD_W = 72;
    localparam int NRM_W  = 18;

    localparam logic signed [NRM_W-1:0] NRM_MAX = 18'sh1FFFF;
    localparam logic signed [NRM_W-1:0] NRM_MIN = 18'sh20000;

    typedef struct packed {
        logic [1:0]         func;
        logic [8:0]         slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [7:0]         corner_a;
        logic [7:0]         corner_b;
        logic [7:0]         corner_c;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] signed_dist;
        logic               inside_res;
        logic               edge_found;
        logic [7:0]         edge_start;
        logic [7:0]         edge_end;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } t_nrm;

endpackage

// ===== rtl/core/chpq_if.sv =====
// Valid/ready channel interfaces for input and result items.
// Depends on chpq_pkg for the payload types.
interface chpq_in_if;
    logic                valid;
    logic                ready;
    chpq_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface chpq_out_if;
    logic                valid;
    logic                ready;
    chpq_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/chpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/convex_hull_point_query.sv =====
// Channel    | dir | payload                                   | accepted when
// i_in       | in  | func, slot, coord_x/y/z, corner_a/b/c     | valid & ready
// o_out      | out | signed_dist, inside_res, edge_found, s/e  | valid & ready
// i_cfg_*    | in  | register index, 32-bit data               | i_cfg_we
//
// A query walks the facets: per facet a facet RAM read and three vertex RAM
// reads, then the shared 36x36 multiplier for the plane distance and for each
// edge, and a 32-step restoring divider for the projection parameter.
// Reset clears control state and config; the stores are undefined until written.
// A result waiting on o_out does not stop writes; a finished query holds until
// the output register is free. Depends on chpq_pkg, chpq_if, chpq_ram.
`include "convex_hull_point_query_defines.svh"
module convex_hull_point_query #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_FACETS   = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chpq_in_if.sink     i_in,
    chpq_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import chpq_pkg::*;

    localparam int VA_W  = $clog2(MAX_VERTICES);
    localparam int FA_W  = $clog2(MAX_FACETS);
    localparam int FC_W  = $clog2(MAX_FACETS + 1);
    localparam int VRAM_W = 96;
    localparam int FRAM_W = 3 * NRM_W + 3 * VA_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FRD  = 4'd1;
    localparam logic [3:0] ST_FLAT = 4'd2;
    localparam logic [3:0] ST_V0   = 4'd3;
    localparam logic [3:0] ST_V1   = 4'd4;
    localparam logic [3:0] ST_V2   = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_ACC  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_OMUL = 4'd9;
    localparam logic [3:0] ST_OSUB = 4'd10;
    localparam logic [3:0] ST_QMUL = 4'd11;
    localparam logic [3:0] ST_QACC = 4'd12;
    localparam logic [3:0] ST_CMP  = 4'd13;
    localparam logic [3:0] ST_NEXT = 4'd14;
    localparam logic [3:0] ST_DONE = 4'd15;

    localparam logic [1:0] PH_PLANE = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_DOT   = 2'd2;

    // Corner index reduction table, built at elaboration
    function automatic logic [256*VA_W-1:0] build_corner_tbl();
        logic [256*VA_W-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < 256; i++) begin
            tbl[i*VA_W +: VA_W] = VA_W'(i % MAX_VERTICES);
        end
        return tbl;
    endfunction

    localparam logic [256*VA_W-1:0] CORNER_TBL = build_corner_tbl();

    function automatic logic signed [31:0] vsel(input t_vec v, input logic [1:0] k);
        case (k)
            2'd0:    return v.x;
            2'd1:    return v.y;
            default: return v.z;
        endcase
    endfunction

    function automatic logic signed [NRM_W-1:0] nsel(input t_nrm n, input logic [1:0] k);
        case (k)
            2'd0:    return n.x;
            2'd1:    return n.y;
            default: return n.z;
        endcase
    endfunction

    function automatic logic signed [NRM_W-1:0] sat_nrm(input logic signed [31:0] v);
        if (v > 32'sd131071) begin
            return NRM_MAX;
        end else if (v < -32'sd131072) begin
            return NRM_MIN;
        end
        return v[NRM_W-1:0];
    endfunction

    // Registers
    logic [3:0]              r_state;
    logic [1:0]              r_phase;
    logic [1:0]              r_k;
    logic [1:0]              r_edge;
    logic [FC_W-1:0]         r_f;
    logic [FC_W-1:0]         r_nf;
    logic [9:0]              r_cfg_count;
    logic signed [31:0]      r_margin;
    t_vec                    r_p;
    t_nrm                    r_n;
    t_vec                    r_v0, r_v1, r_v2;
    logic [VA_W-1:0]         r_c0, r_c1, r_c2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [53:0]      r_best;
    logic [69:0]             r_len;
    logic [69:0]             r_rem;
    logic [32:0]             r_t;
    logic [4:0]              r_div_cnt;
    logic signed [MUL_W-1:0] r_d;
    logic [PROD_W-1:0]       r_best2;
    logic                    r_found;
    logic [VA_W-1:0]         r_bs, r_be;
    logic                    r_out_valid;
    t_out_item               r_out;

    // Combinational signals
    logic                    w_in_acc;
    logic                    w_vwe, w_fwe;
    logic [VA_W-1:0]         w_vraddr;
    logic [VRAM_W-1:0]       w_vrdata;
    logic [FRAM_W-1:0]       w_fwdata, w_frdata;
    logic [FC_W-1:0]         w_nf;
    logic signed [31:0]      w_s, w_e, w_pk;
    logic signed [32:0]      w_seg, w_wp;
    logic signed [33:0]      w_seg34;
    logic [33:0]             w_seg_mag;
    logic signed [MUL_W-1:0] w_opa, w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_acc_sum;
    logic signed [MUL_W-1:0] w_off;
    logic [69:0]             w_rem2;
    logic                    w_out_free;
    logic signed [54:0]      w_rnd;
    logic signed [38:0]      w_rsh;
    logic signed [31:0]      w_dist;
    logic signed [53:0]      w_mrg;
    t_vec                    w_vrd;
    t_nrm                    w_fnrm;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Store write decode
    assign w_vwe = w_in_acc && (i_in.data.func == FN_VERTEX)
                   && (32'(i_in.data.slot) < 32'(MAX_VERTICES));
    assign w_fwe = w_in_acc && (i_in.data.func == FN_FACET)
                   && (32'(i_in.data.slot) < 32'(MAX_FACETS));
    assign w_fwdata = {sat_nrm(i_in.data.coord_x), sat_nrm(i_in.data.coord_y),
                       sat_nrm(i_in.data.coord_z),
                       CORNER_TBL[i_in.data.corner_a*VA_W +: VA_W],
                       CORNER_TBL[i_in.data.corner_b*VA_W +: VA_W],
                       CORNER_TBL[i_in.data.corner_c*VA_W +: VA_W]};

    assign w_vrd  = w_vrdata;
    assign w_fnrm = w_frdata[FRAM_W-1 -: 3*NRM_W];

    // Vertex read address follows the corner being fetched
    always_comb begin
        case (r_state)
            ST_FLAT: w_vraddr = w_frdata[3*VA_W-1 -: VA_W];
            ST_V0:   w_vraddr = r_c1;
            default: w_vraddr = r_c2;
        endcase
    end

    chpq_ram #(.WIDTH(VRAM_W), .DEPTH(MAX_VERTICES)) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (VA_W'(i_in.data.slot)),
        .i_wdata ({i_in.data.coord_x, i_in.data.coord_y, i_in.data.coord_z}),
        .i_raddr (w_vraddr),
        .o_rdata (w_vrdata)
    );

    chpq_ram #(.WIDTH(FRAM_W), .DEPTH(MAX_FACETS)) u_fram (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (FA_W'(i_in.data.slot)),
        .i_wdata (w_fwdata),
        .i_raddr (r_f[FA_W-1:0]),
        .o_rdata (w_frdata)
    );

    assign w_nf = (32'(r_cfg_count) < 32'(MAX_FACETS)) ? FC_W'(r_cfg_count)
                                                         : FC_W'(MAX_FACETS);

    // Edge terms for the current axis: start is v0, end is v1
    assign w_s       = vsel(r_v0, r_k);
    assign w_e       = vsel(r_v1, r_k);
    assign w_pk      = vsel(r_p, r_k);
    assign w_seg     = {w_e[31], w_e} - {w_s[31], w_s};
    assign w_wp      = {w_pk[31], w_pk} - {w_s[31], w_s};
    assign w_seg34   = {w_seg[32], w_seg};
    assign w_seg_mag = w_seg34[33] ? 34'(-w_seg34) : 34'(w_seg34);

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_OMUL: begin
                w_opa = {2'b00, w_seg_mag};
                w_opb = {3'b000, r_t};
            end
            ST_QMUL: begin
                w_opa = r_d;
                w_opb = r_d;
            end
            default: begin
                case (r_phase)
                    PH_PLANE: begin
                        w_opa = MUL_W'(nsel(r_n, r_k));
                        w_opb = {{3{w_wp[32]}}, w_wp};
                    end
                    PH_LEN: begin
                        w_opa = {{3{w_seg[32]}}, w_seg};
                        w_opb = {{3{w_seg[32]}}, w_seg};
                    end
                    default: begin
                        w_opa = {{3{w_seg[32]}}, w_seg};
                        w_opb = {{3{w_wp[32]}}, w_wp};
                    end
                endcase
            end
        endcase
    end

    assign w_prod    = w_opa * w_opb;
    assign w_acc_sum = r_acc + r_prod;
    assign w_off     = w_seg[32] ? -MUL_W'({2'b00, r_prod[65:32]})
                                 : MUL_W'({2'b00, r_prod[65:32]});
    assign w_rem2    = {r_rem[68:0], 1'b0};

    // Result formatting: round half up, saturate, inside test
    assign w_rnd = {r_best[53], r_best} + 55'sd32768;
    assign w_rsh = w_rnd[54:16];
    always_comb begin
        if (w_rsh > 39'sd2147483647) begin
            w_dist = 32'sh7FFFFFFF;
        end else if (w_rsh < -39'sd2147483648) begin
            w_dist = 32'sh80000000;
        end else begin
            w_dist = w_rsh[31:0];
        end
    end
    assign w_mrg = {{6{r_margin[31]}}, r_margin, 16'h0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_count <= '0;
            r_margin    <= '0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FACET_COUNT:   r_cfg_count <= i_cfg_data[9:0];
                    default:           r_margin    <= i_cfg_data;
                endcase
            end

            // Drop the result once taken, unless a new one loads this cycle
            if (r_out_valid && o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_in.data.func == FN_QUERY)) begin
                        r_p     <= {i_in.data.coord_x, i_in.data.coord_y, i_in.data.coord_z};
                        r_nf    <= w_nf;
                        r_f     <= '0;
                        r_found <= 1'b0;
                        r_bs    <= '0;
                        r_be    <= '0;
                        r_state <= (w_nf == '0) ? ST_DONE : ST_FRD;
                    end
                end
                ST_FRD: r_state <= ST_FLAT;
                ST_FLAT: begin
                    r_n     <= w_fnrm;
                    r_c0    <= w_frdata[3*VA_W-1 -: VA_W];
                    r_c1    <= w_frdata[2*VA_W-1 -: VA_W];
                    r_c2    <= w_frdata[VA_W-1:0];
                    r_state <= ST_V0;
                end
                ST_V0: begin
                    r_v0    <= w_vrd;
                    r_state <= ST_V1;
                end
                ST_V1: begin
                    r_v1    <= w_vrd;
                    r_state <= ST_V2;
                end
                ST_V2: begin
                    r_v2    <= w_vrd;
                    r_phase <= PH_PLANE;
                    r_k     <= 2'd0;
                    r_edge  <= 2'd0;
                    r_acc   <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_k == 2'd2) begin
                        r_k   <= 2'd0;
                        r_acc <= '0;
                        case (r_phase)
                            PH_PLANE: begin
                                if ((r_f == '0) || ($signed(w_acc_sum[53:0]) > r_best)) begin
                                    r_best <= w_acc_sum[53:0];
                                end
                                r_phase <= PH_LEN;
                                r_state <= ST_MUL;
                            end
                            PH_LEN: begin
                                r_len   <= w_acc_sum[69:0];
                                r_phase <= PH_DOT;
                                r_state <= ST_MUL;
                            end
                            default: begin
                                // Clamp the projection, or divide for it
                                if ((r_len == '0) || (w_acc_sum <= 0)) begin
                                    r_t     <= '0;
                                    r_state <= ST_OMUL;
                                end else if (w_acc_sum >= $signed({2'b00, r_len})) begin
                                    r_t     <= {1'b1, 32'h0};
                                    r_state <= ST_OMUL;
                                end else begin
                                    r_rem     <= w_acc_sum[69:0];
                                    r_t       <= '0;
                                    r_div_cnt <= '0;
                                    r_state   <= ST_DIV;
                                end
                            end
                        endcase
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_acc   <= w_acc_sum;
                        r_state <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    if (w_rem2 >= r_len) begin
                        r_rem <= w_rem2 - r_len;
                        r_t   <= {r_t[31:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_t   <= {r_t[31:0], 1'b0};
                    end
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == 5'd31) begin
                        r_state <= ST_OMUL;
                    end
                end
                ST_OMUL: begin
                    r_prod  <= w_prod;
                    r_state <= ST_OSUB;
                end
                ST_OSUB: begin
                    r_d     <= {{3{w_wp[32]}}, w_wp} - w_off;
                    r_state <= ST_QMUL;
                end
                ST_QMUL: begin
                    r_prod  <= w_prod;
                    r_state <= ST_QACC;
                end
                ST_QACC: begin
                    r_acc <= w_acc_sum;
                    if (r_k == 2'd2) begin
                        r_state <= ST_CMP;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= ST_OMUL;
                    end
                end
                ST_CMP: begin
                    // Keep the first strictly closer edge
                    if (!r_found || (PROD_W'(r_acc) < r_best2)) begin
                        r_found <= 1'b1;
                        r_best2 <= PROD_W'(r_acc);
                        r_bs    <= r_c0;
                        r_be    <= r_c1;
                    end
                    // Rotate corners so the next edge starts at v0
                    r_v0   <= r_v1;
                    r_v1   <= r_v2;
                    r_v2   <= r_v0;
                    r_c0   <= r_c1;
                    r_c1   <= r_c2;
                    r_c2   <= r_c0;
                    r_k    <= 2'd0;
                    r_acc  <= '0;
                    r_edge <= r_edge + 2'd1;
                    if (r_edge == 2'd2) begin
                        r_state <= ST_NEXT;
                    end else begin
                        r_phase <= PH_LEN;
                        r_state <= ST_MUL;
                    end
                end
                ST_NEXT: begin
                    r_f     <= r_f + 1'b1;
                    r_state <= ((r_f + 1'b1) == r_nf) ? ST_DONE : ST_FRD;
                end
                default: begin
                    // Load the result register when it is free
                    if (w_out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.edge_found      <= r_found;
                        r_out.edge_start      <= 8'(r_bs);
                        r_out.edge_end        <= 8'(r_be);
                        if (r_nf == '0) begin
                            r_out.signed_dist <= 32'sh7FFFFFFF;
                            r_out.inside_res  <= 1'b1;
                        end else begin
                            r_out.signed_dist <= w_dist;
                            r_out.inside_res  <= (r_best <= w_mrg);
                        end
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // A query with no facets goes straight to the result
    `CHPQ_ASSERT_NXT(a_empty_query, i_clk, i_rst_n,
        w_in_acc && (i_in.data.func == FN_QUERY) && (w_nf == '0), r_state == ST_DONE)
    // An edge is found exactly when facets were walked
    `CHPQ_ASSERT_NOW(a_found_match, i_clk, i_rst_n,
        r_state == ST_DONE, r_found == (r_nf != '0))
    // A finished query with a free output register delivers and returns to idle
    `CHPQ_ASSERT_NXT(a_done_load, i_clk, i_rst_n,
        (r_state == ST_DONE) && w_out_free, r_out_valid && (r_state == ST_IDLE))
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for convex_hull_point_query: loads vertices and facets,
// runs point queries and checks each result against a bit-exact predictor.
// Depends on chpq_pkg, chpq_if and the block's RTL.
module tb;
    import chpq_pkg::*;

    localparam logic [1:0] FN_NONE = 2'd3;
    localparam int N_VERT = 256;
    localparam int N_FACET = 512;

    // Holds a copy of the hull and the queue of predicted query results
    class hull_scoreboard;
        logic signed [31:0] vx [N_VERT];
        logic signed [31:0] vy [N_VERT];
        logic signed [31:0] vz [N_VERT];
        logic signed [17:0] nx [N_FACET];
        logic signed [17:0] ny [N_FACET];
        logic signed [17:0] nz [N_FACET];
        logic [7:0] ca [N_FACET];
        logic [7:0] cb [N_FACET];
        logic [7:0] cc [N_FACET];
        logic [9:0] facet_count;
        logic signed [31:0] margin;
        t_out_item pending_q [$];
        int errors;
        int checked;

        function new();
            facet_count = 0;
            margin = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == CFG_FACET_COUNT) facet_count = val[9:0];
            else margin = val;
        endfunction

        function logic signed [17:0] clip_normal(logic signed [31:0] v);
            if (v > 32'sd131071) return NRM_MAX;
            if (v < -32'sd131072) return NRM_MIN;
            return v[17:0];
        endfunction

        function logic signed [127:0] abs128(logic signed [127:0] v);
            return (v < 0) ? -v : v;
        endfunction

        // Squared distance from point to segment si->ei, projection clamped
        function logic signed [127:0] seg_dist2(logic signed [127:0] px, logic signed [127:0] py,
                                                logic signed [127:0] pz, logic [7:0] si,
                                                logic [7:0] ei);
            logic signed [127:0] seg [3];
            logic signed [127:0] w [3];
            logic signed [127:0] len2, dot, t, off, d, d2;
            len2 = 0;
            dot = 0;
            d2 = 0;
            t = 0;
            seg[0] = vx[ei] - vx[si];
            seg[1] = vy[ei] - vy[si];
            seg[2] = vz[ei] - vz[si];
            w[0] = px - vx[si];
            w[1] = py - vy[si];
            w[2] = pz - vz[si];
            for (int k = 0; k < 3; k++) begin
                len2 += seg[k] * seg[k];
                dot += seg[k] * w[k];
            end
            if (len2 != 0 && dot > 0) begin
                if (dot >= len2) t = 128'sd1 <<< 32;
                else t = (dot <<< 32) / len2;
            end
            for (int k = 0; k < 3; k++) begin
                off = (abs128(seg[k]) * t) >>> 32;
                if (seg[k] < 0) off = -off;
                d = w[k] - off;
                d2 += d * d;
            end
            return d2;
        endfunction

        function t_out_item eval_query(t_in_item it);
            logic signed [127:0] px, py, pz, best, dv, d2, best2, r;
            logic [7:0] cn [3];
            int nf;
            bit found;
            t_out_item res;
            px = it.coord_x;
            py = it.coord_y;
            pz = it.coord_z;
            best = 0;
            best2 = 0;
            found = 0;
            res = '0;
            nf = (facet_count > N_FACET) ? N_FACET : facet_count;
            for (int f = 0; f < nf; f++) begin
                cn[0] = ca[f];
                cn[1] = cb[f];
                cn[2] = cc[f];
                dv = nx[f] * (px - vx[cn[0]]) + ny[f] * (py - vy[cn[0]])
                   + nz[f] * (pz - vz[cn[0]]);
                if (f == 0 || dv > best) best = dv;
                for (int i = 0; i < 3; i++) begin
                    d2 = seg_dist2(px, py, pz, cn[i], cn[(i + 1) % 3]);
                    if (!found || d2 < best2) begin
                        found = 1;
                        best2 = d2;
                        res.edge_start = cn[i];
                        res.edge_end = cn[(i + 1) % 3];
                    end
                end
            end
            res.edge_found = found;
            if (nf == 0) begin
                res.signed_dist = 32'sh7FFFFFFF;
                res.inside_res = 1'b1;
            end else begin
                r = (best + 128'sd32768) >>> 16;
                if (r > 128'sd2147483647) r = 128'sd2147483647;
                if (r < -128'sd2147483648) r = -128'sd2147483648;
                res.signed_dist = r[31:0];
                res.inside_res = (best <= (128'(margin) <<< 16));
            end
            return res;
        endfunction

        // Apply an accepted input item; queue a prediction for a query
        function void note_input(t_in_item it);
            case (it.func)
                FN_VERTEX: begin
                    if (it.slot < N_VERT) begin
                        vx[it.slot] = it.coord_x;
                        vy[it.slot] = it.coord_y;
                        vz[it.slot] = it.coord_z;
                    end
                end
                FN_FACET: begin
                    nx[it.slot] = clip_normal(it.coord_x);
                    ny[it.slot] = clip_normal(it.coord_y);
                    nz[it.slot] = clip_normal(it.coord_z);
                    ca[it.slot] = it.corner_a;
                    cb[it.slot] = it.corner_b;
                    cc[it.slot] = it.corner_c;
                end
                FN_QUERY: pending_q.insert(pending_q.size(), eval_query(it));
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                $error("unexpected result item: %p", got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.signed_dist !== want.signed_dist) begin
                $error("signed_dist expected %0d actual %0d", want.signed_dist, got.signed_dist);
                errors++;
            end
            if (got.inside_res !== want.inside_res) begin
                $error("inside_res expected %0d actual %0d", want.inside_res, got.inside_res);
                errors++;
            end
            if (got.edge_found !== want.edge_found) begin
                $error("edge_found expected %0d actual %0d", want.edge_found, got.edge_found);
                errors++;
            end
            if (got.edge_start !== want.edge_start) begin
                $error("edge_start expected %0d actual %0d", want.edge_start, got.edge_start);
                errors++;
            end
            if (got.edge_end !== want.edge_end) begin
                $error("edge_end expected %0d actual %0d", want.edge_end, got.edge_end);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    chpq_in_if  in_ch ();
    chpq_out_if out_ch ();

    convex_hull_point_query i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    hull_scoreboard sb = new();
    bit   vert_written [N_VERT];
    int   vert_list [$];
    bit   tx_calm;
    bit   rx_calm;
    int   n_items;
    int   n_queries;

    // Run the 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    // Stall the result side at random, with calm stretches
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        rx_calm = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            n = rx_calm ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
        end
    end

    // Send one item after a random gap and hold it until accepted
    task automatic send_item(t_in_item it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(it);
        n_items++;
        if (it.func == FN_QUERY) n_queries++;
        if (it.func == FN_VERTEX && it.slot < N_VERT && !vert_written[it.slot]) begin
            vert_written[it.slot] = 1;
            vert_list.insert(vert_list.size(), int'(it.slot));
        end
    endtask

    // Hold off until every predicted result is in and the block is quiet
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic put_vertex(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in_item it;
        it = '0;
        it.func = FN_VERTEX;
        it.slot = 9'(slot);
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.corner_a = 8'($urandom);
        it.corner_b = 8'($urandom);
        it.corner_c = 8'($urandom);
        send_item(it);
    endtask

    task automatic put_facet(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [7:0] a, logic [7:0] b, logic [7:0] c);
        t_in_item it;
        it = '0;
        it.func = FN_FACET;
        it.slot = 9'(slot);
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.corner_a = a;
        it.corner_b = b;
        it.corner_c = c;
        send_item(it);
    endtask

    task automatic put_query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in_item it;
        it = '0;
        it.func = FN_QUERY;
        it.slot = 9'($urandom);
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.corner_a = 8'($urandom);
        it.corner_b = 8'($urandom);
        it.corner_c = 8'($urandom);
        send_item(it);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h7FFFFFFF) | ($urandom_range(0, 1) << 31);
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_normal();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [7:0] rand_corner();
        return 8'(vert_list[$urandom_range(0, vert_list.size() - 1)]);
    endfunction

    task automatic rand_facet(int slot);
        put_facet(slot, rand_normal(), rand_normal(), rand_normal(),
                  rand_corner(), rand_corner(), rand_corner());
    endtask

    // Load a small random hull, then query it with writes and noise mixed in
    task automatic run_hull(int nf, int nq);
        t_in_item it;
        tx_calm = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 4)) put_vertex($urandom_range(0, 255), rand_coord(),
                                                 rand_coord(), rand_coord());
        for (int f = 0; f < nf; f++) rand_facet(f);
        wait_idle();
        write_reg(CFG_FACET_COUNT, nf);
        case ($urandom_range(0, 3))
            0: write_reg(CFG_INSIDE_MARGIN, $urandom);
            1: write_reg(CFG_INSIDE_MARGIN, $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
            default: write_reg(CFG_INSIDE_MARGIN, 32'($urandom_range(0, 32'h40000)) - 32'h20000);
        endcase
        repeat (nq) begin
            case ($urandom_range(0, 9))
                0: put_vertex($urandom_range(0, 511), rand_coord(), rand_coord(), rand_coord());
                1: if (nf > 0) rand_facet($urandom_range(0, nf - 1));
                2: begin
                    it = '0;
                    it.func = FN_NONE;
                    it.slot = 9'($urandom);
                    it.coord_x = $urandom;
                    send_item(it);
                end
                default: put_query(rand_coord(), rand_coord(), rand_coord());
            endcase
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_FACET_COUNT;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        n_items = 0;
        n_queries = 0;
        tx_calm = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No facets loaded: saturated distance, inside, no edge
        put_query(32'h0, 32'h0, 32'h0);
        put_query(32'h80000000, 32'h7FFFFFFF, 32'h12345678);

        // Unit tetrahedron, a coincident corner and extreme corners
        put_vertex(0, 32'h0, 32'h0, 32'h0);
        put_vertex(1, 32'h0001_0000, 32'h0, 32'h0);
        put_vertex(2, 32'h0, 32'h0001_0000, 32'h0);
        put_vertex(3, 32'h0, 32'h0, 32'h0001_0000);
        put_vertex(4, 32'h0, 32'h0, 32'h0);
        put_vertex(5, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        put_vertex(6, 32'h80000000, 32'h80000000, 32'h80000000);
        put_vertex(255, 32'hFFFF_0000, 32'h0003_8000, 32'hFFFF_FFFF);
        put_vertex(128, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
        // Vertex slot past the store is dropped
        put_vertex(300, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
        put_facet(0, 32'hFFFF_0000, 32'h0, 32'h0, 8'd0, 8'd1, 8'd2);
        // Normal components beyond Q2.16 clip; edge 0 -> 4 has zero length
        put_facet(1, 32'h7FFFFFFF, 32'h80000000, 32'h0001_0000, 8'd0, 8'd4, 8'd3);
        put_facet(2, 32'h0001_FFFF, 32'hFFFE_0000, 32'h0, 8'd5, 8'd6, 8'd255);
        put_facet(3, 32'h0, 32'h0, 32'h0001_0000, 8'd128, 8'd3, 8'd1);
        wait_idle();
        write_reg(CFG_FACET_COUNT, 32'd4);
        write_reg(CFG_INSIDE_MARGIN, 32'h80000000);
        put_query(32'h0, 32'h0, 32'h0);
        put_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        put_query(32'h80000000, 32'h80000000, 32'h80000000);
        put_query(32'h0000_4000, 32'h0000_4000, 32'hFFFF_C000);
        wait_idle();
        write_reg(CFG_INSIDE_MARGIN, 32'h7FFFFFFF);
        put_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        put_query(32'h0, 32'h0, 32'h0);
        begin
            t_in_item it;
            it = '0;
            it.func = FN_NONE;
            it.slot = 9'h1FF;
            send_item(it);
        end
        wait_idle();
        write_reg(CFG_INSIDE_MARGIN, 32'h0);
        write_reg(CFG_FACET_COUNT, 32'd1);
        put_query(32'h0001_0000, 32'h0001_0000, 32'h0);

        // Random hulls, mostly small
        while (n_items < 390) begin
            if ($urandom_range(0, 7) == 0) run_hull($urandom_range(10, 40), 4);
            else run_hull($urandom_range(0, 6), $urandom_range(4, 12));
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("run covered %0d input items, %0d queries, %0d results checked",
                 n_items, n_queries, sb.checked);
        $display("facet counts from 0 to 40, margins at both extremes, random idling");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #200_000_000;
        $display("tb failed");
        $finish;
    end
endmodule
